FILE: design/fss_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and the load pattern for the firing squad automaton
package fss_pkg;

    // field widths fixed by the item formats
    localparam int LEN_W       = 7;
    localparam int PROBE_W     = 6;
    localparam int STEP_W      = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // reset value of the squad length register
    localparam int SQUAD_LENGTH_RESET = 8;

    // register indexes
    localparam logic REG_SQUAD_LENGTH = 1'b0;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // message codes
    localparam logic [2:0] MSG_NONE    = 3'd0;
    localparam logic [2:0] MSG_TEST    = 3'd1;
    localparam logic [2:0] MSG_MIDTEST = 3'd2;
    localparam logic [2:0] MSG_MIDACK  = 3'd3;
    localparam logic [2:0] MSG_RESET   = 3'd4;
    localparam logic [2:0] MSG_PROMOTE = 3'd5;

    // direction codes
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_BOTH  = 2'd2;

    // state of one cell
    typedef struct packed {
        logic       gen;
        logic       red;
        logic       act;
        logic       tst;
        logic [1:0] tmr;
        logic [2:0] msg;
        logic [1:0] dir;
    } t_cell;

    // per-cell control from the top level
    typedef struct packed {
        logic load;
        logic step;
        logic first;
        logic last;
        logic used;
        logic has_right;
        logic rst_last;
        logic rst_used;
    } t_cell_ctl;

    // initial squad pattern for one cell given its role
    function automatic t_cell f_pattern(input logic first, input logic last,
                                        input logic used);
        t_cell c;
        c = '0;
        if (last) begin
            c.gen = 1'b1;
            c.red = 1'b1;
            c.dir = DIR_LEFT;
        end else if (first && used) begin
            c.gen = 1'b1;
            c.red = 1'b1;
            c.act = 1'b1;
            c.tst = 1'b1;
            c.dir = DIR_RIGHT;
        end else if (used) begin
            c.act = 1'b1;
            c.dir = DIR_BOTH;
        end
        return c;
    endfunction

endpackage

FILE: design/fss_apb_regs.sv
`timescale 1ns / 1ps
// apb configuration register for the squad length
module fss_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fss_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fss_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fss_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [fss_pkg::LEN_W-1:0]       o_squad_length
);
    import fss_pkg::*;

    logic [LEN_W-1:0] r_squad_length;
    logic             w_hit;

    // word decode, byte lanes ignored
    assign w_hit  = (paddr[APB_ADDR_W-1] == REG_SQUAD_LENGTH);
    assign pready = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_squad_length <= LEN_W'(SQUAD_LENGTH_RESET);
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_squad_length <= pwdata[LEN_W-1:0];
        end
    end

    // read back
    assign prdata = w_hit ? APB_DATA_W'(r_squad_length) : '0;
    assign o_squad_length = r_squad_length;

endmodule

FILE: design/fss_cell.sv
`timescale 1ns / 1ps
// one finite-state cell of the firing squad row
module fss_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fss_pkg::t_cell_ctl i_ctl,
    input  fss_pkg::t_cell     i_left,
    input  fss_pkg::t_cell     i_right,
    output fss_pkg::t_cell     o_state
);
    import fss_pkg::*;

    t_cell      r_cell;
    t_cell      n_cell;
    logic [2:0] w_lm;
    logic [2:0] w_rm;
    logic       w_has_left;

    // turn this cell into a red general that sends reset
    function automatic t_cell f_general(input t_cell c, input logic [1:0] dir);
        t_cell g;
        g     = c;
        g.gen = 1'b1;
        g.red = 1'b1;
        g.act = 1'b1;
        g.tst = 1'b1;
        g.msg = MSG_RESET;
        g.dir = dir;
        return g;
    endfunction

    assign w_has_left = !i_ctl.first;

    // messages arriving from the neighbors
    always_comb begin
        w_lm = MSG_NONE;
        w_rm = MSG_NONE;
        if (w_has_left && (i_left.dir == DIR_RIGHT || i_left.dir == DIR_BOTH)) begin
            w_lm = i_left.msg;
        end
        if (i_ctl.has_right && (i_right.dir == DIR_LEFT || i_right.dir == DIR_BOTH)) begin
            w_rm = i_right.msg;
        end
    end

    // next state from old self and neighbors
    always_comb begin
        n_cell = r_cell;
        if (r_cell.gen) begin
            // general
            if (w_lm == MSG_RESET || w_rm == MSG_RESET) begin
                n_cell.act = 1'b0;
            end else begin
                n_cell.msg = MSG_NONE;
                if (w_rm == MSG_MIDTEST && w_lm == MSG_MIDTEST) begin
                    n_cell.msg = MSG_MIDACK;
                    n_cell.dir = DIR_BOTH;
                end else if (w_rm == MSG_MIDTEST) begin
                    n_cell.msg = MSG_MIDACK;
                    n_cell.dir = DIR_RIGHT;
                end else if (w_lm == MSG_MIDTEST) begin
                    n_cell.msg = MSG_MIDACK;
                    n_cell.dir = DIR_LEFT;
                end else if (r_cell.act) begin
                    if (r_cell.tst) begin
                        n_cell.msg = MSG_TEST;
                        n_cell.tst = 1'b0;
                        n_cell.dir = DIR_BOTH;
                    end else if ((w_lm == MSG_TEST && w_has_left && !i_left.gen) ||
                                 (w_rm == MSG_TEST && i_ctl.has_right && !i_right.gen)) begin
                        n_cell.tst = 1'b1;
                    end
                end
            end
        end else if (w_lm == MSG_PROMOTE) begin
            n_cell = f_general(r_cell, DIR_RIGHT);
        end else if (w_rm == MSG_PROMOTE) begin
            n_cell = f_general(r_cell, DIR_LEFT);
        end else if (r_cell.msg == MSG_PROMOTE) begin
            // own promote comes back as a general facing away
            n_cell     = f_general(r_cell, (r_cell.dir == DIR_RIGHT) ? DIR_LEFT : DIR_RIGHT);
            n_cell.tmr = 2'd0;
        end else if (w_lm == MSG_NONE && w_rm == MSG_NONE) begin
            n_cell.msg = MSG_NONE;
            if (r_cell.tmr != 2'd0) begin
                n_cell.tmr = r_cell.tmr - 2'd1;
            end
        end else if (w_lm == MSG_RESET || w_rm == MSG_RESET) begin
            n_cell.act = 1'b1;
            n_cell.msg = MSG_RESET;
            n_cell.dir = (w_lm == MSG_RESET) ? DIR_RIGHT : DIR_LEFT;
        end else if (r_cell.act) begin
            // active soldier
            n_cell.act = 1'b1;
            if (w_lm == MSG_TEST || w_rm == MSG_TEST) begin
                n_cell.dir = DIR_BOTH;
                n_cell.msg = MSG_MIDTEST;
                n_cell.tst = 1'b1;
            end else if (w_lm == MSG_MIDACK && w_rm == MSG_MIDACK) begin
                n_cell.gen = 1'b1;
                n_cell.red = 1'b1;
                n_cell.tst = 1'b1;
                n_cell.msg = MSG_RESET;
                n_cell.dir = DIR_BOTH;
            end else if (w_lm == MSG_MIDACK || w_rm == MSG_MIDACK) begin
                if (!r_cell.tst) begin
                    n_cell.msg = MSG_MIDACK;
                    n_cell.dir = (w_rm == MSG_MIDACK) ? DIR_LEFT : DIR_RIGHT;
                end else begin
                    n_cell.act = 1'b0;
                    n_cell.msg = MSG_NONE;
                    n_cell.tmr = 2'd3;
                end
            end else if (w_lm != MSG_NONE) begin
                n_cell.dir = DIR_RIGHT;
                n_cell.msg = w_lm;
            end else begin
                n_cell.dir = DIR_LEFT;
                n_cell.msg = w_rm;
            end
        end else begin
            // passive soldier
            n_cell.act = 1'b0;
            if (r_cell.tmr != 2'd0) begin
                n_cell.tmr = r_cell.tmr - 2'd1;
            end
            if (r_cell.tst && (w_rm == MSG_MIDACK || w_lm == MSG_MIDACK)) begin
                n_cell.tst = 1'b0;
                if (r_cell.tmr != 2'd0) begin
                    n_cell.msg = MSG_PROMOTE;
                    n_cell.dir = (w_rm == MSG_MIDACK) ? DIR_RIGHT : DIR_LEFT;
                    n_cell.tmr = 2'd0;
                end else begin
                    n_cell.msg = MSG_TEST;
                    n_cell.dir = (w_rm == MSG_MIDACK) ? DIR_LEFT : DIR_RIGHT;
                end
            end else if (w_lm != MSG_NONE) begin
                n_cell.dir = DIR_RIGHT;
                n_cell.msg = w_lm;
            end else begin
                n_cell.dir = DIR_LEFT;
                n_cell.msg = w_rm;
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= f_pattern(i_ctl.first, i_ctl.rst_last, i_ctl.rst_used);
        end else if (i_ctl.load) begin
            r_cell <= f_pattern(i_ctl.first, i_ctl.last, i_ctl.used);
        end else if (i_ctl.step && i_ctl.used) begin
            r_cell <= n_cell;
        end
    end

    assign o_state = r_cell;

endmodule

FILE: design/firing_squad_sync_automaton.sv
`timescale 1ns / 1ps
// firing squad synchronization: a row of MAX_CELLS cells, all stepped in the same cycle
// every cell updates in parallel at the accept edge, and the item is then held pending
// throughput: one item per cycle unless the output register is stalled
// the all-red check and probe select run on the pending item, into the output register
// reset (synchronous, active low) loads the squad pattern for length 8 and clears
// the step count, the fired flag and both valid flags
module firing_squad_sync_automaton #(
    parameter int MAX_CELLS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // s_axis_tdata: [5:0] probe_cell
    input  logic [fss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // s_axis_tuser: [0] cmd
    input  logic [fss_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // m_axis_tdata: [0] fired, [16:1] step_count, [17] probe_is_general, [18] probe_red,
    // [19] probe_active, [20] probe_testing, [22:21] probe_timer, [25:23] probe_message,
    // [27:26] probe_direction
    output logic [fss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fss_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fss_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fss_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import fss_pkg::*;

    localparam int NW    = $clog2(MAX_CELLS + 1);
    localparam int SW    = $clog2(MAX_CELLS);
    localparam int EW    = (NW > LEN_W) ? NW : LEN_W;
    localparam int PEW   = (NW > PROBE_W) ? NW : PROBE_W;
    localparam int RST_N = (SQUAD_LENGTH_RESET > MAX_CELLS) ? MAX_CELLS : SQUAD_LENGTH_RESET;

    logic [LEN_W-1:0]   w_squad_length;
    logic [EW-1:0]      w_len_ext;
    logic [NW-1:0]      w_len;
    logic               w_accept;
    logic               w_move;
    logic               w_cmd;
    logic               w_load;
    logic               w_step;
    logic               w_all_red;
    logic               w_fired_cur;
    logic [PEW-1:0]     w_probe_ext;
    logic               w_probe_ok;
    t_cell              w_probe_cell;
    t_cell              w_state [MAX_CELLS];
    t_cell_ctl          w_ctl [MAX_CELLS];
    logic [MAX_CELLS-1:0] w_red_ok;

    logic               r_pend;
    logic               r_pend_step;
    logic [PROBE_W-1:0] r_probe;
    logic [STEP_W-1:0]  r_steps;
    logic               r_fired;
    logic               r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;

    // configuration register
    fss_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_squad_length (w_squad_length)
    );

    // effective squad length, clamped to 1..MAX_CELLS
    assign w_len_ext = EW'(w_squad_length);
    always_comb begin
        if (w_len_ext == '0) begin
            w_len = NW'(1);
        end else if (w_len_ext > EW'(MAX_CELLS)) begin
            w_len = NW'(MAX_CELLS);
        end else begin
            w_len = w_len_ext[NW-1:0];
        end
    end

    // handshake: the output register frees the pending slot
    assign w_move        = r_pend && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_pend || w_move;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = s_axis_tuser[0];

    // fired status including a step whose all-red check is still pending
    assign w_all_red   = &w_red_ok;
    assign w_fired_cur = (r_pend && r_pend_step) ? w_all_red : r_fired;
    assign w_load      = w_accept && (w_cmd == CMD_LOAD);
    assign w_step      = w_accept && (w_cmd == CMD_STEP) && !w_fired_cur;

    // row of cells
    for (genvar j = 0; j < MAX_CELLS; j++) begin : g_cell
        assign w_ctl[j].load      = w_load;
        assign w_ctl[j].step      = w_step;
        assign w_ctl[j].first     = (j == 0);
        assign w_ctl[j].last      = (NW'(j + 1) == w_len);
        assign w_ctl[j].used      = (NW'(j) < w_len);
        assign w_ctl[j].has_right = (NW'(j + 1) < w_len);
        assign w_ctl[j].rst_last  = (j + 1 == RST_N);
        assign w_ctl[j].rst_used  = (j < RST_N);
        assign w_red_ok[j]        = w_state[j].red || !w_ctl[j].used;

        if (j == 0) begin : g_left_edge
            if (MAX_CELLS > 1) begin : g_right
                fss_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (w_ctl[j]),
                    .i_left  ('0),
                    .i_right (w_state[j+1]),
                    .o_state (w_state[j])
                );
            end
        end else if (j == MAX_CELLS - 1) begin : g_right_edge
            fss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[j]),
                .i_left  (w_state[j-1]),
                .i_right ('0),
                .o_state (w_state[j])
            );
        end else begin : g_inner
            fss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[j]),
                .i_left  (w_state[j-1]),
                .i_right (w_state[j+1]),
                .o_state (w_state[j])
            );
        end
    end

    // probe select
    assign w_probe_ext  = PEW'(r_probe);
    assign w_probe_ok   = (w_probe_ext < PEW'(MAX_CELLS));
    assign w_probe_cell = w_probe_ok ? w_state[w_probe_ext[SW-1:0]] : '0;

    // result packing
    assign n_out_data = {4'b0, w_probe_cell.dir, w_probe_cell.msg, w_probe_cell.tmr,
                         w_probe_cell.tst, w_probe_cell.act, w_probe_cell.red,
                         w_probe_cell.gen, r_steps, w_fired_cur};

    // control: pending item, step count, fired flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_pend_step <= 1'b0;
            r_steps     <= '0;
            r_fired     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pend      <= 1'b1;
                r_pend_step <= w_step;
            end else if (w_move) begin
                r_pend      <= 1'b0;
            end

            if (w_load) begin
                r_steps <= '0;
            end else if (w_step && (r_steps != '1)) begin
                r_steps <= r_steps + STEP_W'(1);
            end

            r_fired <= w_load ? 1'b0 : w_fired_cur;

            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_probe <= s_axis_tdata[PROBE_W-1:0];
        end
        if (w_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tdata  = r_out_data;
    assign m_axis_tvalid = r_out_valid;

    // a load clears the step count
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_steps == '0))
        else $error("step count not cleared by load");

    // a step after firing leaves the count alone
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_STEP) && w_fired_cur) |=> $stable(r_steps))
        else $error("step count moved after firing");

    // firing takes at least one step
    a_fired_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fired |-> (r_steps != '0))
        else $error("fired with zero steps");

    // input stalls only while an item waits for the output register
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_pend && r_out_valid && !m_axis_tready))
        else $error("input stalled without a waiting item");

endmodule

FILE: tb/sv/tb_firing_squad_sync_automaton.sv
`timescale 1ns / 1ps
// self-checking stream and register testbench for the firing squad automaton
module tb_firing_squad_sync_automaton;
    import fss_pkg::*;

    localparam int          SQUAD_CELLS = 64;
    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          RANDOM_ITEMS = 1300;
    localparam logic [15:0] STEP_MAX = 16'hFFFF;

    typedef struct {
        logic       cmd;
        logic [5:0] probe;
    } t_squad_item;

    typedef struct {
        logic        fired;
        logic [15:0] steps;
        t_cell       probed;
    } t_squad_result;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    // clock, reset and block ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    // s_axis_tdata: [5:0] probe_cell, [7:6] zero
    logic [IN_TDATA_W-1:0]     s_axis_tdata = '0;
    // s_axis_tuser: [0] cmd
    logic [IN_TUSER_W-1:0]     s_axis_tuser = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // m_axis_tdata: [0] fired, [16:1] step_count, [17] probe_is_general, [18] probe_red,
    // [19] probe_active, [20] probe_testing, [22:21] probe_timer, [25:23] probe_message,
    // [27:26] probe_direction
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0]     pwdata = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    // squad predictor state
    t_cell       squad_cells [SQUAD_CELLS];
    t_cell       prior_cells [SQUAD_CELLS];
    logic [6:0]  squad_len_reg;
    logic [15:0] squad_steps;
    logic        squad_fired;

    // stimulus and checking bookkeeping
    t_squad_item   pending_items[$];
    t_squad_result expected_results[$];
    int            items_queued = 0;
    int            items_taken = 0;
    int            results_seen = 0;
    int            mismatches = 0;
    int            load_count = 0;
    int            step_count = 0;
    int            fire_count = 0;
    int            peak_steps = 0;
    int            cycles = 0;
    logic          item_taken = 1'b0;
    logic          no_idle = 1'b0;
    int            burst_left = 1;
    int            gap_left = 0;
    int            rx_count = 0;
    t_rx_mode      rx_mode = RX_ALWAYS;

    firing_squad_sync_automaton #(
        .MAX_CELLS(SQUAD_CELLS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // length in use, with zero and oversize folded in
    function automatic int squad_span();
        if (squad_len_reg == 7'd0) return 1;
        if (int'(squad_len_reg) > SQUAD_CELLS) return SQUAD_CELLS;
        return int'(squad_len_reg);
    endfunction

    // start pattern: left general testing, soldiers active, right general passive
    function automatic void load_squad();
        int n;
        n = squad_span();
        foreach (squad_cells[k]) squad_cells[k] = '0;
        squad_cells[0].gen = 1'b1;
        squad_cells[0].red = 1'b1;
        squad_cells[0].act = 1'b1;
        squad_cells[0].tst = 1'b1;
        squad_cells[0].dir = DIR_RIGHT;
        for (int k = 1; k + 1 < n; k++) begin
            squad_cells[k].act = 1'b1;
            squad_cells[k].dir = DIR_BOTH;
        end
        squad_cells[n-1] = '0;
        squad_cells[n-1].gen = 1'b1;
        squad_cells[n-1].red = 1'b1;
        squad_cells[n-1].dir = DIR_LEFT;
        squad_steps = '0;
        squad_fired = 1'b0;
    endfunction

    // a soldier promoted to red general that sends reset
    function automatic t_cell promote(input t_cell c, input logic [1:0] dir);
        t_cell g;
        g = c;
        g.gen = 1'b1;
        g.red = 1'b1;
        g.act = 1'b1;
        g.tst = 1'b1;
        g.msg = MSG_RESET;
        g.dir = dir;
        return g;
    endfunction

    // new state of cell j from the previous states of itself and its neighbors
    function automatic t_cell next_cell(input int j, input int n);
        t_cell      o;
        t_cell      c;
        logic [2:0] lm;
        logic [2:0] rm;
        logic [2:0] msg;
        logic [1:0] dir;
        logic [1:0] toward;
        logic       act;
        o = prior_cells[j];
        c = o;
        lm = MSG_NONE;
        rm = MSG_NONE;
        msg = MSG_NONE;
        dir = o.dir;
        act = o.act;
        if (j > 0 && (prior_cells[j-1].dir == DIR_RIGHT || prior_cells[j-1].dir == DIR_BOTH))
            lm = prior_cells[j-1].msg;
        if (j + 1 < n && (prior_cells[j+1].dir == DIR_LEFT || prior_cells[j+1].dir == DIR_BOTH))
            rm = prior_cells[j+1].msg;

        if (o.gen) begin
            // a reset from either side puts a general to rest
            if (lm == MSG_RESET || rm == MSG_RESET) begin
                c.act = 1'b0;
                return c;
            end
            if (rm == MSG_MIDTEST && lm == MSG_MIDTEST) begin
                msg = MSG_MIDACK;
                dir = DIR_BOTH;
            end else if (rm == MSG_MIDTEST) begin
                msg = MSG_MIDACK;
                dir = DIR_RIGHT;
            end else if (lm == MSG_MIDTEST) begin
                msg = MSG_MIDACK;
                dir = DIR_LEFT;
            end else if (o.act) begin
                if (o.tst) begin
                    msg = MSG_TEST;
                    c.tst = 1'b0;
                    dir = DIR_BOTH;
                end else if ((lm == MSG_TEST && j > 0 && !prior_cells[j-1].gen) ||
                             (rm == MSG_TEST && j + 1 < n && !prior_cells[j+1].gen)) begin
                    c.tst = 1'b1;
                end
            end
        end else begin
            // promotion to general, from a neighbor or from itself
            if (lm == MSG_PROMOTE) return promote(c, DIR_RIGHT);
            if (rm == MSG_PROMOTE) return promote(c, DIR_LEFT);
            if (o.msg == MSG_PROMOTE) begin
                c = promote(c, (o.dir == DIR_RIGHT) ? DIR_LEFT : DIR_RIGHT);
                c.tmr = 2'd0;
                return c;
            end
            // quiet neighbors: the message clears and the timer runs down
            if (lm == MSG_NONE && rm == MSG_NONE) begin
                c.msg = MSG_NONE;
                if (o.tmr != 2'd0) c.tmr = o.tmr - 2'd1;
                return c;
            end
            if (lm == MSG_RESET || rm == MSG_RESET) begin
                act = 1'b1;
                msg = MSG_RESET;
                dir = (lm == MSG_RESET) ? DIR_RIGHT : DIR_LEFT;
            end else if (o.act) begin
                act = 1'b1;
                if (lm == MSG_TEST || rm == MSG_TEST) begin
                    dir = DIR_BOTH;
                    msg = MSG_MIDTEST;
                    c.tst = 1'b1;
                end else if (lm == MSG_MIDACK && rm == MSG_MIDACK) begin
                    // exact middle of an odd sub-squad
                    c.gen = 1'b1;
                    c.red = 1'b1;
                    c.tst = 1'b1;
                    msg = MSG_RESET;
                    dir = DIR_BOTH;
                end else if (rm == MSG_MIDACK || lm == MSG_MIDACK) begin
                    if (!o.tst) begin
                        msg = MSG_MIDACK;
                        dir = (rm == MSG_MIDACK) ? DIR_LEFT : DIR_RIGHT;
                    end else begin
                        act = 1'b0;
                        msg = MSG_NONE;
                        c.tmr = 2'd3;
                    end
                end else if (lm != MSG_NONE) begin
                    dir = DIR_RIGHT;
                    msg = lm;
                end else begin
                    dir = DIR_LEFT;
                    msg = rm;
                end
            end else begin
                // passive soldier: relay, or finish a middle search
                act = 1'b0;
                if (o.tmr != 2'd0) c.tmr = o.tmr - 2'd1;
                if (o.tst && (rm == MSG_MIDACK || lm == MSG_MIDACK)) begin
                    toward = (rm == MSG_MIDACK) ? DIR_RIGHT : DIR_LEFT;
                    c.tst = 1'b0;
                    if (o.tmr >= 2'd1) begin
                        msg = MSG_PROMOTE;
                        dir = toward;
                        c.tmr = 2'd0;
                    end else begin
                        msg = MSG_TEST;
                        dir = (toward == DIR_RIGHT) ? DIR_LEFT : DIR_RIGHT;
                    end
                end else if (lm != MSG_NONE) begin
                    dir = DIR_RIGHT;
                    msg = lm;
                end else begin
                    dir = DIR_LEFT;
                    msg = rm;
                end
            end
        end
        c.act = act;
        c.dir = dir;
        c.msg = msg;
        return c;
    endfunction

    // one time step of the whole squad, frozen once fired
    function automatic void advance_squad();
        int   n;
        logic all_red;
        n = squad_span();
        if (!squad_fired) begin
            prior_cells = squad_cells;
            for (int k = 0; k < n; k++) squad_cells[k] = next_cell(k, n);
            if (squad_steps != STEP_MAX) squad_steps = squad_steps + 16'd1;
            all_red = 1'b1;
            for (int k = 0; k < n; k++) if (!squad_cells[k].red) all_red = 1'b0;
            squad_fired = all_red;
            if (all_red) fire_count++;
            if (int'(squad_steps) > peak_steps) peak_steps = int'(squad_steps);
        end
    endfunction

    // apply one accepted item and store the result it should give
    function automatic void apply_item(input logic cmd, input logic [5:0] probe);
        t_squad_result r;
        if (cmd == CMD_LOAD) begin
            load_squad();
            load_count++;
        end else begin
            advance_squad();
            step_count++;
        end
        r.fired = squad_fired;
        r.steps = squad_steps;
        r.probed = squad_cells[probe];
        expected_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // cycle counter with a hard stop
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // input side: note accepted items and run the predictor on them
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            item_taken = 1'b1;
            items_taken++;
            apply_item(s_axis_tuser[0], s_axis_tdata[5:0]);
        end
    end

    // input driver: bursts of items with random gaps between them
    always @(negedge i_clk) begin : drive_proc
        t_squad_item nxt;
        if (i_rst_n && (!s_axis_tvalid || item_taken)) begin
            item_taken = 1'b0;
            if (gap_left != 0 && !no_idle) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                s_axis_tuser <= nxt.cmd;
                s_axis_tdata <= {2'b00, nxt.probe};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side backpressure, switching at random among four patterns
    always @(negedge i_clk) begin
        rx_count++;
        if (rx_count % 64 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_ALWAYS:   m_axis_tready <= 1'b1;
                RX_RANDOM:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_axis_tready <= (rx_count % 4 != 0);
                default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker against the oldest stored result
    always @(posedge i_clk) begin : check_proc
        t_squad_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result item arrived with none outstanding");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("fired", want.fired, m_axis_tdata[0]);
                check_field("step_count", want.steps, m_axis_tdata[16:1]);
                check_field("probe_is_general", want.probed.gen, m_axis_tdata[17]);
                check_field("probe_red", want.probed.red, m_axis_tdata[18]);
                check_field("probe_active", want.probed.act, m_axis_tdata[19]);
                check_field("probe_testing", want.probed.tst, m_axis_tdata[20]);
                check_field("probe_timer", want.probed.tmr, m_axis_tdata[22:21]);
                check_field("probe_message", want.probed.msg, m_axis_tdata[25:23]);
                check_field("probe_direction", want.probed.dir, m_axis_tdata[27:26]);
            end
        end
    end

    task automatic queue_item(input logic cmd, input logic [5:0] probe);
        t_squad_item it;
        it.cmd = cmd;
        it.probe = probe;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // probe mostly inside the squad, sometimes anywhere
    function automatic logic [5:0] pick_probe();
        if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, squad_span() - 1));
    endfunction

    task automatic queue_steps(input int count);
        for (int k = 0; k < count; k++) queue_item(CMD_STEP, pick_probe());
    endtask

    // wait until every item is taken and every result is back
    task automatic settle();
        do @(negedge i_clk);
        while (items_taken != items_queued || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // write the squad length, then read it back
    task automatic set_length(input logic [6:0] value);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_SQUAD_LENGTH, 2'b00};
        pwdata <= {25'($urandom_range(0, 32'h01FF_FFFF)), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        squad_len_reg = value;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        check_field("squad_length", {25'd0, value}, prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // stimulus: directed cases, random runs, then a short run with no idling
    initial begin : stim_proc
        int       n;
        int       run_steps;
        int       split;
        int       pick;
        int       random_base;
        squad_len_reg = 7'(SQUAD_LENGTH_RESET);
        load_squad();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // stepping straight out of reset, then plain loads
        queue_item(CMD_STEP, 6'd0);
        queue_item(CMD_STEP, 6'd7);
        queue_item(CMD_STEP, 6'd63);
        queue_item(CMD_LOAD, 6'd0);
        queue_item(CMD_LOAD, 6'd63);
        // single cell fires at once and then stays frozen
        set_length(7'd1);
        queue_item(CMD_LOAD, 6'd0);
        queue_item(CMD_STEP, 6'd0);
        queue_item(CMD_STEP, 6'd0);
        queue_item(CMD_STEP, 6'd63);
        // zero length behaves as one
        set_length(7'd0);
        queue_item(CMD_LOAD, 6'd0);
        queue_item(CMD_STEP, 6'd1);
        // two generals only
        set_length(7'd2);
        queue_item(CMD_LOAD, 6'd1);
        queue_item(CMD_STEP, 6'd1);
        queue_item(CMD_STEP, 6'd0);
        // oversize length folds to the full row
        set_length(7'd127);
        queue_item(CMD_LOAD, 6'd63);
        queue_item(CMD_STEP, 6'd63);
        queue_item(CMD_STEP, 6'd62);
        set_length(7'd64);
        queue_item(CMD_LOAD, 6'd0);
        queue_item(CMD_STEP, 6'd1);
        // length grows while running, with no reload
        set_length(7'd3);
        queue_item(CMD_LOAD, 6'd1);
        queue_item(CMD_STEP, 6'd2);
        set_length(7'd5);
        queue_item(CMD_STEP, 6'd4);
        queue_item(CMD_STEP, 6'd3);
        settle();

        // random runs: load, step until about the firing time, some disturbed
        random_base = items_queued;
        while (items_queued - random_base < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) set_length(7'($urandom_range(1, 16)));
            else if (pick <= 7) set_length(7'($urandom_range(17, 64)));
            else if (pick == 8) set_length(($urandom_range(0, 1) == 0) ? 7'd0
                                           : 7'($urandom_range(65, 127)));
            n = squad_span();
            queue_item(CMD_LOAD, pick_probe());
            run_steps = $urandom_range(n, 3 * n + 12);
            if ($urandom_range(0, 4) == 0) begin
                // change the length part way through the run
                split = $urandom_range(1, run_steps);
                queue_steps(split);
                set_length(7'($urandom_range(1, 64)));
                queue_steps(run_steps - split);
            end else if ($urandom_range(0, 9) == 0) begin
                // stray reload in the middle of a run
                split = $urandom_range(1, run_steps);
                queue_steps(split);
                queue_item(CMD_LOAD, pick_probe());
                queue_steps(run_steps - split);
            end else begin
                queue_steps(run_steps);
            end
        end
        settle();

        // back to back items with no idling, length grown mid run
        no_idle = 1'b1;
        set_length(7'd8);
        queue_item(CMD_LOAD, 6'd0);
        queue_steps(2);
        set_length(7'd64);
        queue_steps(50);
        settle();
        no_idle = 1'b0;

        repeat (8) @(posedge i_clk);
        $display("covered %0d loads and %0d steps; %0d result items checked",
                 load_count, step_count, results_seen);
        $display("squad fired %0d times, highest step count %0d", fire_count, peak_steps);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
